[rtl/swrl_pkg.sv]
// Package for the sliding window rate limiter.
// Holds the controller state type, register indexes, field widths and reset values.
// No dependencies.
package swrl_pkg;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_CHECK
    } t_state;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LIMIT   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SECONDS = 1'b1;

    // Fixed field widths
    localparam int unsigned LIMIT_W    = 7;
    localparam int unsigned WINSEC_W   = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned CALLS_W    = 7;
    localparam int unsigned OUT_DATA_W = 8;

    // Register reset values
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 7'd49;
    localparam logic [WINSEC_W-1:0] WINSEC_RESET = 16'd1;

endpackage

[rtl/swrl_stamp_ram.sv]
// Stamp store of the rate limiter: one write port, one read port,
// read data registered. No dependencies.
module swrl_stamp_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sliding_window_rate_limiter_unit.sv]
// Sliding window rate limiter, top level. Uses swrl_pkg and swrl_stamp_ram.
// Controller, configuration registers and result register live here.
//
// Each request carries the current time in seconds. Stamps of granted requests sit in a
// ring in a single-port-read memory; on each request the controller expires stamps from
// the oldest end whose age exceeds window_seconds, then grants and records the stamp if
// fewer than window_limit (capped at DEPTH) stamps remain. One result per request: bit 0
// granted, bits 7:1 stamps held afterwards. Expired stamps are dropped one at a time, since
// every expiry waits for the next read of the memory; then comes a decide step, and the
// controller returns to idle, in which the next oldest stamp is read and the next request
// is accepted. The result waits in an output register; a stalled output holds the decide
// step. No clearing pass after reset.
module sliding_window_rate_limiter_unit
    import swrl_pkg::*;
#(
    parameter int unsigned DEPTH     = 64,
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [NOW_W-1:0]      i_s_axis_tdata,   // [31:0] now
    // Result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [0] granted, [7:1] calls_in_window
    // Configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int unsigned IDX_W   = $clog2(DEPTH);
    localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W   = CNT_W + 1;
    localparam int unsigned CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int unsigned AGE_W   = (TIME_BITS > WINSEC_W) ? TIME_BITS : WINSEC_W;
    localparam int unsigned NOWX_W  = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;
    localparam int unsigned CALLX_W = (CNT_W > CALLS_W) ? CNT_W : CALLS_W;

    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

    // Registers
    t_state                r_state, n_state;
    logic [LIMIT_W-1:0]    r_window_limit;
    logic [WINSEC_W-1:0]   r_window_seconds;
    logic [TIME_BITS-1:0]  r_now, n_now;
    logic [IDX_W-1:0]      r_oldest, n_oldest;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    // Memory interface
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [TIME_BITS-1:0]  mem_rdata;

    // Datapath
    logic [NOWX_W-1:0]     now_ext;
    logic [TIME_BITS-1:0]  age;
    logic                  expire;
    logic [CMP_W-1:0]      limit_sat;
    logic                  grant;
    logic [SUM_W-1:0]      slot_sum;
    logic [CNT_W-1:0]      count_after;
    logic [CALLX_W-1:0]    calls_ext;
    logic                  s_xfer;
    logic                  out_free;

    swrl_stamp_ram #(
        .DEPTH (DEPTH),
        .WIDTH (TIME_BITS)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_now),
        .i_raddr (n_oldest),
        .o_rdata (mem_rdata)
    );

    assign s_xfer   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign now_ext  = NOWX_W'(i_s_axis_tdata);

    // Age of the oldest stamp, wrapping in the time width
    assign age    = r_now - mem_rdata;
    assign expire = (r_count != '0) && (AGE_W'(age) > AGE_W'(r_window_seconds));

    // Limit capped at the ring depth
    assign limit_sat = (CMP_W'(r_window_limit) > DEPTH_CMP) ? DEPTH_CMP
                                                            : CMP_W'(r_window_limit);
    assign grant     = CMP_W'(r_count) < limit_sat;

    // Next free slot: oldest + count, wrapped once
    assign slot_sum  = SUM_W'(r_oldest) + SUM_W'(r_count);
    assign mem_waddr = (slot_sum >= DEPTH_SUM) ? IDX_W'(slot_sum - DEPTH_SUM)
                                               : IDX_W'(slot_sum);
    assign mem_we    = (r_state == ST_CHECK) && !expire && out_free && grant;

    assign count_after = grant ? r_count + CNT_W'(1) : r_count;
    assign calls_ext   = CALLX_W'(count_after);

    // Next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_oldest    = r_oldest;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        unique case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    n_now   = now_ext[TIME_BITS-1:0];
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (expire) begin
                    // drop the oldest stamp and read the next one
                    n_oldest = (r_oldest == LAST_IDX) ? '0 : r_oldest + IDX_W'(1);
                    n_count  = r_count - CNT_W'(1);
                end else if (out_free) begin
                    n_count     = count_after;
                    n_out_valid = 1'b1;
                    n_out_data  = {calls_ext[CALLS_W-1:0], grant};
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_oldest    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_out_data <= n_out_data;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_limit   <= LIMIT_RESET;
            r_window_seconds <= WINSEC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_WINDOW_LIMIT:   r_window_limit   <= i_cfg_wdata[LIMIT_W-1:0];
                REG_WINDOW_SECONDS: r_window_seconds <= i_cfg_wdata[WINSEC_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= DEPTH_CMP)
        else $error("stamp count above ring depth");

    a_accept_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer |=> (r_state == ST_CHECK))
        else $error("accepted request did not start a check");

    a_write_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (CMP_W'(r_count) < DEPTH_CMP))
        else $error("stamp written into a full ring");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + CNT_W'(1)) ||
             (r_count == $past(r_count) - CNT_W'(1))))
        else $error("stamp count moved by more than one");

    a_grant_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[0]) |-> (r_out_data[OUT_DATA_W-1:1] != '0))
        else $error("grant reported with an empty ring");
`endif

endmodule
